// ----- rtl/mlso_pkg.sv -----
// Package for the mip level size and offset block: widths, codes and limits.
`default_nettype none
package mlso_pkg;

  // Field and register widths
  localparam int unsigned DimW      = 15;
  localparam int unsigned KindW     = 2;
  localparam int unsigned PixW      = 5;
  localparam int unsigned LayCntW   = 12;
  localparam int unsigned LvlW      = 4;
  localparam int unsigned LayerW    = 11;
  localparam int unsigned FaceW     = 3;
  localparam int unsigned SizeW     = 47;
  localparam int unsigned OffW      = 60;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 15;

  // Internal widths
  localparam int unsigned BlkW      = 14;  // ceil(width / 4) for a 15-bit width
  localparam int unsigned LineW     = 20;  // width * bytes per pixel
  localparam int unsigned LhW       = 35;  // line * effective height
  localparam int unsigned LhLoW     = 18;
  localparam int unsigned LhHiW     = LhW - LhLoW;
  localparam int unsigned VolW      = 50;  // line * height * depth before clamp
  localparam int unsigned IdxW      = 14;  // layer * faces + face
  localparam int unsigned SzLoW     = 24;
  localparam int unsigned SzHiW     = SizeW - SzLoW;
  localparam int unsigned OffSumW   = 61;

  // Limits
  localparam int unsigned MaxDimLog2 = 14;
  localparam logic [FaceW-1:0] CubeFaces = FaceW'(6);
  localparam logic [FaceW-1:0] FlatFaces = FaceW'(1);

  // Compression kinds
  typedef enum logic [KindW-1:0] {
    KIND_NONE = 2'd0,
    KIND_DXT1 = 2'd1,
    KIND_DXT3 = 2'd2,
    KIND_DXT5 = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBaseWidth  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegBaseHeight = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBaseDepth  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegKind       = 4'd3;
  localparam logic [CfgIdxW-1:0] RegPixBytes   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLayerCount = 4'd5;
  localparam logic [CfgIdxW-1:0] RegIsCube     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegLevelCount = 4'd7;

  // Shift a base dimension down by the level, clamped to at least one
  function automatic logic [DimW-1:0] shrink(input logic [DimW-1:0] dim,
                                             input logic [LvlW-1:0] lvl);
    logic [DimW-1:0] v;
    v = dim >> lvl;
    return (v == '0) ? DimW'(1) : v;
  endfunction

  // Count of 4-pixel blocks covering a dimension
  function automatic logic [BlkW-1:0] blocks_of(input logic [DimW-1:0] n);
    logic [DimW:0] s;
    s = {1'b0, n} + (DimW+1)'(3);
    return s[DimW:2];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mip_level_size_and_offset.sv -----
// Top level: pipelined mip level image size and sub-image byte offset.
`default_nettype none
// Each request beat (level, layer, face) yields one result beat with the image
// size of that mip level, the byte offset (layer * faces + face) * size, and a
// bad_index flag (size and offset read zero when it is set). The block takes
// one beat per cycle unless a result beat is held; the six register stages
// hold the dimension shrink, the line-times-height multiply, the depth multiply
// as two partial products, the clamped sum, the offset partial products and the
// clamped offset. A stall on a valid result beat freezes all stages and is passed
// back on in_stall in the same cycle. Configuration writes are taken at any
// time and are meant to happen while no beat is in flight.
module mip_level_size_and_offset (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration
  input  wire logic                          cfg_write,
  input  wire logic [mlso_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mlso_pkg::CfgDataW-1:0] cfg_data,
  // Request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mlso_pkg::LvlW-1:0]     level,
  input  wire logic [mlso_pkg::LayerW-1:0]   layer,
  input  wire logic [mlso_pkg::FaceW-1:0]    face,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mlso_pkg::SizeW-1:0]         level_size,
  output logic [mlso_pkg::OffW-1:0]          byte_offset,
  output logic                               bad_index
);

  // Configuration registers
  logic [mlso_pkg::DimW-1:0]    base_width;
  logic [mlso_pkg::DimW-1:0]    base_height;
  logic [mlso_pkg::DimW-1:0]    base_depth;
  mlso_pkg::kind_t              compression_kind;
  logic [mlso_pkg::PixW-1:0]    pixel_bytes;
  logic [mlso_pkg::LayCntW-1:0] layer_count;
  logic                         is_cube;
  logic [mlso_pkg::LvlW-1:0]    level_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_width       <= mlso_pkg::DimW'(1);
      base_height      <= mlso_pkg::DimW'(1);
      base_depth       <= mlso_pkg::DimW'(1);
      compression_kind <= mlso_pkg::KIND_NONE;
      pixel_bytes      <= mlso_pkg::PixW'(4);
      layer_count      <= mlso_pkg::LayCntW'(1);
      is_cube          <= 1'b0;
      level_count      <= mlso_pkg::LvlW'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mlso_pkg::RegBaseWidth:  base_width  <= cfg_data[mlso_pkg::DimW-1:0];
        mlso_pkg::RegBaseHeight: base_height <= cfg_data[mlso_pkg::DimW-1:0];
        mlso_pkg::RegBaseDepth:  base_depth  <= cfg_data[mlso_pkg::DimW-1:0];
        mlso_pkg::RegKind:
          compression_kind <= mlso_pkg::kind_t'(cfg_data[mlso_pkg::KindW-1:0]);
        mlso_pkg::RegPixBytes:   pixel_bytes <= cfg_data[mlso_pkg::PixW-1:0];
        mlso_pkg::RegLayerCount: layer_count <= cfg_data[mlso_pkg::LayCntW-1:0];
        mlso_pkg::RegIsCube:     is_cube     <= cfg_data[0];
        mlso_pkg::RegLevelCount: level_count <= cfg_data[mlso_pkg::LvlW-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the result beat is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: range check, face index, shrunk dimensions, line size
  logic [mlso_pkg::FaceW-1:0]  faces;
  logic                        bad_c;
  logic [mlso_pkg::IdxW-1:0]   idx_c;
  logic [mlso_pkg::DimW-1:0]   w_c;
  logic [mlso_pkg::DimW-1:0]   h_c;
  logic [mlso_pkg::LineW-1:0]  line_c;
  logic [mlso_pkg::DimW-1:0]   effh_c;

  always_comb begin
    faces = is_cube ? mlso_pkg::CubeFaces : mlso_pkg::FlatFaces;
    bad_c = (level >= level_count) ||
            (mlso_pkg::LvlW'(mlso_pkg::MaxDimLog2) < level) ||
            ({1'b0, layer} >= layer_count) ||
            (face >= faces);
    if (is_cube) begin
      idx_c = (mlso_pkg::IdxW'(layer) << 2) + (mlso_pkg::IdxW'(layer) << 1) +
              mlso_pkg::IdxW'(face);
    end else begin
      idx_c = mlso_pkg::IdxW'(layer) + mlso_pkg::IdxW'(face);
    end
    w_c = mlso_pkg::shrink(base_width, level);
    h_c = mlso_pkg::shrink(base_height, level);
    unique case (compression_kind)
      mlso_pkg::KIND_NONE: begin
        line_c = mlso_pkg::LineW'(w_c) * mlso_pkg::LineW'(pixel_bytes);
        effh_c = h_c;
      end
      mlso_pkg::KIND_DXT1: begin
        line_c = mlso_pkg::LineW'(mlso_pkg::blocks_of(w_c)) << 3;
        effh_c = mlso_pkg::DimW'(mlso_pkg::blocks_of(h_c));
      end
      default: begin
        line_c = mlso_pkg::LineW'(mlso_pkg::blocks_of(w_c)) << 4;
        effh_c = mlso_pkg::DimW'(mlso_pkg::blocks_of(h_c));
      end
    endcase
  end

  logic                        v1, bad1;
  logic [mlso_pkg::IdxW-1:0]   idx1;
  logic [mlso_pkg::LineW-1:0]  line1;
  logic [mlso_pkg::DimW-1:0]   effh1;
  logic [mlso_pkg::DimW-1:0]   d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad1  <= bad_c;
      idx1  <= idx_c;
      line1 <= line_c;
      effh1 <= effh_c;
      d1    <= mlso_pkg::shrink(base_depth, level);
    end
  end

  // Stage 2: line times effective height
  logic                        v2, bad2;
  logic [mlso_pkg::IdxW-1:0]   idx2;
  logic [mlso_pkg::LhW-1:0]    lh2;
  logic [mlso_pkg::DimW-1:0]   d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad2 <= bad1;
      idx2 <= idx1;
      lh2  <= mlso_pkg::LhW'(line1) * mlso_pkg::LhW'(effh1);
      d2   <= d1;
    end
  end

  // Stage 3: depth multiply as two partial products
  localparam int unsigned PLoW = mlso_pkg::LhLoW + mlso_pkg::DimW;
  localparam int unsigned PHiW = mlso_pkg::LhHiW + mlso_pkg::DimW;

  logic                        v3, bad3;
  logic [mlso_pkg::IdxW-1:0]   idx3;
  logic [PLoW-1:0]             plo3;
  logic [PHiW-1:0]             phi3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad3 <= bad2;
      idx3 <= idx2;
      plo3 <= PLoW'(lh2[mlso_pkg::LhLoW-1:0]) * PLoW'(d2);
      phi3 <= PHiW'(lh2[mlso_pkg::LhW-1:mlso_pkg::LhLoW]) * PHiW'(d2);
    end
  end

  // Stage 4: sum partial products and clamp the image size
  logic [mlso_pkg::VolW-1:0]   vol_c;
  logic [mlso_pkg::SizeW-1:0]  size_c;

  always_comb begin
    vol_c = mlso_pkg::VolW'(plo3) + (mlso_pkg::VolW'(phi3) << mlso_pkg::LhLoW);
    if (vol_c[mlso_pkg::VolW-1:mlso_pkg::SizeW] != '0) begin
      size_c = '1;
    end else begin
      size_c = vol_c[mlso_pkg::SizeW-1:0];
    end
  end

  logic                        v4, bad4;
  logic [mlso_pkg::IdxW-1:0]   idx4;
  logic [mlso_pkg::SizeW-1:0]  size4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad4  <= bad3;
      idx4  <= idx3;
      size4 <= size_c;
    end
  end

  // Stage 5: offset multiply as two partial products
  localparam int unsigned QLoW = mlso_pkg::SzLoW + mlso_pkg::IdxW;
  localparam int unsigned QHiW = mlso_pkg::SzHiW + mlso_pkg::IdxW;

  logic                        v5, bad5;
  logic [mlso_pkg::SizeW-1:0]  size5;
  logic [QLoW-1:0]             qlo5;
  logic [QHiW-1:0]             qhi5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad5  <= bad4;
      size5 <= size4;
      qlo5  <= QLoW'(size4[mlso_pkg::SzLoW-1:0]) * QLoW'(idx4);
      qhi5  <= QHiW'(size4[mlso_pkg::SizeW-1:mlso_pkg::SzLoW]) * QHiW'(idx4);
    end
  end

  // Stage 6: sum, clamp the offset, zero the fields of a bad request
  logic [mlso_pkg::OffSumW-1:0] off_c;
  logic [mlso_pkg::OffW-1:0]    offc_c;

  always_comb begin
    off_c = mlso_pkg::OffSumW'(qlo5) +
            (mlso_pkg::OffSumW'(qhi5) << mlso_pkg::SzLoW);
    if (off_c[mlso_pkg::OffSumW-1]) begin
      offc_c = '1;
    end else begin
      offc_c = off_c[mlso_pkg::OffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_index   <= bad5;
      level_size  <= bad5 ? '0 : size5;
      byte_offset <= bad5 ? '0 : offc_c;
    end
  end

endmodule
`default_nettype wire

// ----- tb/mip_result_checker.sv -----
// Checker for the mip level size and offset block: predicts each result and compares it.
module mip_result_checker
  import mlso_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [LvlW-1:0]     level,
  input  wire logic [LayerW-1:0]   layer,
  input  wire logic [FaceW-1:0]    face,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [SizeW-1:0]    level_size,
  input  wire logic [OffW-1:0]     byte_offset,
  input  wire logic                bad_index,
  output logic [31:0]              mismatches,
  output logic [31:0]              pending,
  output logic [31:0]              beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] BlockEdge       = 64'd4;
  localparam logic [63:0] SmallBlockBytes = 64'd8;
  localparam logic [63:0] BigBlockBytes   = 64'd16;
  localparam logic [63:0] SizeCeiling     = (64'd1 << SizeW) - 64'd1;
  localparam logic [63:0] OffsetCeiling   = (64'd1 << OffW) - 64'd1;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  offset;
    logic             bad;
  } mip_result_t;

  // Texture description as last written
  logic [DimW-1:0]    tex_w, tex_h, tex_d;
  kind_t              tex_kind;
  logic [PixW-1:0]    tex_pix;
  logic [LayCntW-1:0] tex_layers;
  logic               tex_cube;
  logic [LvlW-1:0]    tex_levels;

  mip_result_t results_due[$];

  // Image size and sub-image offset for one request under the current texture
  function automatic mip_result_t mip_result_of(input logic [LvlW-1:0] lvl,
                                                input logic [LayerW-1:0] lay,
                                                input logic [FaceW-1:0] fc);
    mip_result_t r;
    logic [63:0] faces, w, h, d, line, rows, vol, idx, off;
    r = '0;
    faces = tex_cube ? 64'(CubeFaces) : 64'(FlatFaces);
    if (lvl >= tex_levels || lvl > MaxDimLog2 || lay >= tex_layers || fc >= faces) begin
      r.bad = 1'b1;
      return r;
    end
    // Shrink each dimension, never below one
    w = 64'(tex_w) >> lvl;
    h = 64'(tex_h) >> lvl;
    d = 64'(tex_d) >> lvl;
    if (w == 0) w = 64'd1;
    if (h == 0) h = 64'd1;
    if (d == 0) d = 64'd1;
    case (tex_kind)
      KIND_NONE: begin
        line = w * 64'(tex_pix);
        rows = h;
      end
      KIND_DXT1: begin
        line = ((w + BlockEdge - 1) / BlockEdge) * SmallBlockBytes;
        rows = (h + BlockEdge - 1) / BlockEdge;
      end
      default: begin
        line = ((w + BlockEdge - 1) / BlockEdge) * BigBlockBytes;
        rows = (h + BlockEdge - 1) / BlockEdge;
      end
    endcase
    // Clamp size, then offset from the clamped size
    vol = line * rows * d;
    r.size = (vol > SizeCeiling) ? SizeCeiling[SizeW-1:0] : vol[SizeW-1:0];
    idx = 64'(lay) * faces + 64'(fc);
    off = idx * 64'(r.size);
    r.offset = (off > OffsetCeiling) ? OffsetCeiling[OffW-1:0] : off[OffW-1:0];
    return r;
  endfunction

  // Compare result beats, queue predictions for request beats, track register writes
  always @(posedge clk) begin
    mip_result_t want;
    logic wrong;
    if (rst) begin
      tex_w = DimW'(1);
      tex_h = DimW'(1);
      tex_d = DimW'(1);
      tex_kind = KIND_NONE;
      tex_pix = PixW'(4);
      tex_layers = LayCntW'(1);
      tex_cube = 1'b0;
      tex_levels = LvlW'(1);
      results_due.delete();
      mismatches = 0;
      beats_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing pending: size %0d offset %0d bad %0b",
                     $realtime, level_size, byte_offset, bad_index);
          mismatches = mismatches + 1;
        end else begin
          want = results_due.pop_front();
          wrong = (level_size !== want.size) || (byte_offset !== want.offset) ||
                  (bad_index !== want.bad);
          if (wrong) begin
            if (mismatches < 10)
              $display("%0t: mismatch size %0d/%0d offset %0d/%0d bad %0b/%0b (exp/got)",
                       $realtime, want.size, level_size, want.offset, byte_offset,
                       want.bad, bad_index);
            mismatches = mismatches + 1;
          end
          beats_checked = beats_checked + 1;
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(mip_result_of(level, layer, face));
      if (cfg_write) begin
        case (cfg_index)
          RegBaseWidth:  tex_w = cfg_data[DimW-1:0];
          RegBaseHeight: tex_h = cfg_data[DimW-1:0];
          RegBaseDepth:  tex_d = cfg_data[DimW-1:0];
          RegKind:       tex_kind = kind_t'(cfg_data[KindW-1:0]);
          RegPixBytes:   tex_pix = cfg_data[PixW-1:0];
          RegLayerCount: tex_layers = cfg_data[LayCntW-1:0];
          RegIsCube:     tex_cube = cfg_data[0];
          RegLevelCount: tex_levels = cfg_data[LvlW-1:0];
          default: ;
        endcase
      end
    end
    pending = results_due.size();
  end

endmodule

// ----- tb/tb_mip_level_size_and_offset.sv -----
// Testbench top for the mip level size and offset block: stimulus, idling and verdict.
module tb_mip_level_size_and_offset;
  timeunit 1ns;
  timeprecision 1ps;
  import mlso_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 12;
  localparam int PhaseCount   = 10;
  localparam int PhaseBeats   = 40;
  localparam int WellFormPct  = 85;
  localparam logic [CfgDataW-1:0] DimTop = 15'h7FFF;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [LvlW-1:0]     level;
  logic [LayerW-1:0]   layer;
  logic [FaceW-1:0]    face;
  logic                out_valid;
  logic                out_stall;
  logic [SizeW-1:0]    level_size;
  logic [OffW-1:0]     byte_offset;
  logic                bad_index;
  logic [31:0]         mismatches;
  logic [31:0]         pending;
  logic [31:0]         beats_checked;

  int send_idle_pct = 9;
  int rcv_idle_pct  = 62;
  int quiet_cycles  = 0;
  int requests_sent = 0;
  int settings_used = 1;

  // Register values in force, as the block sees them
  logic [LvlW-1:0]    eff_levels = LvlW'(1);
  logic [LayCntW-1:0] eff_layers = LayCntW'(1);
  logic               eff_cube   = 1'b0;

  mip_level_size_and_offset uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .level(level), .layer(layer), .face(face),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_size(level_size), .byte_offset(byte_offset), .bad_index(bad_index)
  );

  mip_result_checker result_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .level(level), .layer(layer), .face(face),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_size(level_size), .byte_offset(byte_offset), .bad_index(bad_index),
    .mismatches(mismatches), .pending(pending), .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: stall at random
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("timeout: no beat moved for %0d cycles, %0d results pending",
               StallLimit, pending);
      $display("tb_mip_level_size_and_offset NOT OK");
      $finish;
    end
  end

  // Send one request beat after a random gap; hold it until taken
  task automatic send_req(input int unsigned l, input int unsigned y,
                          input int unsigned f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    level <= LvlW'(l);
    layer <= LayerW'(y);
    face <= FaceW'(f);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Drop valid and wait for every pending result
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_one(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Load a full texture description while the block is idle
  task automatic load_regs(input logic [CfgDataW-1:0] w, h, d, k, p, lc, cb, lv);
    quiesce();
    write_one(RegBaseWidth, w);
    write_one(RegBaseHeight, h);
    write_one(RegBaseDepth, d);
    write_one(RegKind, k);
    write_one(RegPixBytes, p);
    write_one(RegLayerCount, lc);
    write_one(RegIsCube, cb);
    write_one(RegLevelCount, lv);
    cfg_write <= 1'b0;
    eff_levels = lv[LvlW-1:0];
    eff_layers = lc[LayCntW-1:0];
    eff_cube = cb[0];
    settings_used++;
  endtask

  // Occasionally set bits above a narrow register's width
  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned v, input int unsigned w);
    if ($urandom_range(0, 3) == 0)
      return CfgDataW'(v | ($urandom << w));
    return CfgDataW'(v);
  endfunction

  function automatic logic [CfgDataW-1:0] random_dim();
    case ($urandom_range(0, 3))
      0: return CfgDataW'($urandom_range(1, 64));
      1: return CfgDataW'($urandom_range(0, 32767));
      default: return CfgDataW'((1 << $urandom_range(0, 14)) + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic random_regs();
    logic [CfgDataW-1:0] w, h, d, k, p, lc, cb, lv;
    w = random_dim();
    h = random_dim();
    d = random_dim();
    k = with_junk($urandom_range(0, 3), KindW);
    p = with_junk(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
                  PixW);
    case ($urandom_range(0, 7))
      0: lc = with_junk($urandom_range(0, 4095), LayCntW);
      1, 2: lc = with_junk($urandom_range(1, 8), LayCntW);
      default: lc = with_junk($urandom_range(1, 2048), LayCntW);
    endcase
    cb = with_junk($urandom_range(0, 1), 1);
    lv = with_junk(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 15),
                   LvlW);
    load_regs(w, h, d, k, p, lc, cb, lv);
  endtask

  // Mostly in-range requests, the rest anything the fields allow
  task automatic send_random();
    int unsigned lv_hi, ly_hi;
    if (eff_levels != 0 && eff_layers != 0 && $urandom_range(0, 99) < WellFormPct) begin
      lv_hi = eff_levels - 1;
      if (lv_hi > MaxDimLog2) lv_hi = MaxDimLog2;
      ly_hi = eff_layers - 1;
      if (ly_hi > (1 << LayerW) - 1) ly_hi = (1 << LayerW) - 1;
      send_req($urandom_range(0, lv_hi), $urandom_range(0, ly_hi),
               $urandom_range(0, eff_cube ? CubeFaces - 1 : FlatFaces - 1));
    end else begin
      send_req($urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    level <= '0;
    layer <= '0;
    face <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset texture: one level, one layer, flat
    send_req(0, 0, 0);
    send_req(1, 0, 0);
    send_req(0, 1, 0);
    send_req(0, 0, 1);

    // Largest everything: size and offset clamp, bad level and bad face
    load_regs(DimTop, DimTop, DimTop, CfgDataW'(KIND_NONE), CfgDataW'(31), CfgDataW'(4095),
              CfgDataW'(1), CfgDataW'(15));
    send_req(0, 0, 0);
    send_req(0, 2047, 5);
    send_req(14, 2047, 5);
    send_req(15, 0, 0);
    send_req(3, 0, 6);

    // Zero base dimensions clamp to one; zero pixel bytes ignored when compressed
    load_regs(CfgDataW'(0), CfgDataW'(0), CfgDataW'(0), CfgDataW'(KIND_DXT1), CfgDataW'(0),
              CfgDataW'(2048), CfgDataW'(0), CfgDataW'(15));
    send_req(0, 0, 0);
    send_req(3, 2047, 0);
    send_req(14, 5, 0);

    // Odd sizes with partial blocks on a small cube array
    load_regs(CfgDataW'(5), CfgDataW'(7), CfgDataW'(3), CfgDataW'(KIND_DXT3), CfgDataW'(0),
              CfgDataW'(3), CfgDataW'(1), CfgDataW'(4));
    send_req(0, 0, 0);
    send_req(1, 2, 5);
    send_req(3, 1, 3);
    send_req(4, 0, 0);
    send_req(0, 3, 0);

    load_regs(CfgDataW'(16384), CfgDataW'(1), CfgDataW'(16384), CfgDataW'(KIND_DXT5),
              CfgDataW'(16), CfgDataW'(1), CfgDataW'(0), CfgDataW'(15));
    send_req(0, 0, 0);
    send_req(13, 0, 0);

    // Uncompressed with zero pixel bytes
    load_regs(CfgDataW'(100), CfgDataW'(3), CfgDataW'(2), CfgDataW'(KIND_NONE), CfgDataW'(0),
              CfgDataW'(1), CfgDataW'(0), CfgDataW'(1));
    send_req(0, 0, 0);

    // Zero layer and level counts flag everything
    load_regs(CfgDataW'(1), CfgDataW'(1), CfgDataW'(1), CfgDataW'(KIND_NONE), CfgDataW'(1),
              CfgDataW'(0), CfgDataW'(0), CfgDataW'(0));
    send_req(0, 0, 0);
    send_req(15, 2047, 7);

    // Random textures; idling moves from the result side to the request side, then stops
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 62;
        rcv_idle_pct = 9;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      random_regs();
      repeat (PhaseBeats) send_random();
    end

    quiesce();
    repeat (DrainCycles) @(negedge clk);
    $display("covered %0d request beats under %0d register settings (all compression kinds,",
             requests_sent, settings_used);
    $display("cube and flat, clamped sizes, bad indexes); %0d results checked, %0d mismatches",
             beats_checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("tb_mip_level_size_and_offset OK");
    else
      $display("tb_mip_level_size_and_offset NOT OK");
    $finish;
  end

endmodule
